[rtl/core/double_ended_array_with_reverse_top_macros.svh]
// assertion macros shared by the deque core
`ifndef DOUBLE_ENDED_ARRAY_WITH_REVERSE_TOP_MACROS_SVH
`define DOUBLE_ENDED_ARRAY_WITH_REVERSE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DEWR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define DEWR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define DEWR_ASSERT(label, prop, msg)
`define DEWR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/core/dewr_pkg.sv]
`default_nettype none
package dewr_pkg;

    localparam int ELEM_W   = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam logic [ACTION_W-1:0] ACT_DUMP       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REVERSE    = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [ELEM_W-1:0] value;
    } dewr_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic [STATUS_W-1:0]      status;
        logic                     last;
        logic [FILL_W-1:0]        fill_count;
    } dewr_out_t;

    typedef struct packed {
        logic exec;
        logic dump_start;
        logic dump_step;
    } dewr_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic out_free;
        logic dump_last;
    } dewr_sts_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } dewr_state_t;

endpackage
`default_nettype wire

[rtl/core/dewr_ctrl.sv]
`default_nettype none
`include "double_ended_array_with_reverse_top_macros.svh"
module dewr_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [2:0]                action,
    input  wire dewr_pkg::dewr_sts_t       sts,
    output dewr_pkg::dewr_cmd_t            cmd
);
    import dewr_pkg::*;

    dewr_state_t state_reg, state_next;
    logic        accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && action == ACT_DUMP && !sts.cnt_zero) begin
                    state_next = S_DUMP;
                end
            end
            S_DUMP: begin
                if (sts.out_free && sts.dump_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = sts.out_free;
                if (accept) begin
                    if (action == ACT_DUMP && !sts.cnt_zero) begin
                        cmd.dump_start = 1'b1;
                    end else begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            S_DUMP: begin
                cmd.dump_step = sts.out_free;
            end
            default: ;
        endcase
    end

    `DEWR_ASSERT(a_ctrl_one_cmd, $onehot0(cmd), "more than one datapath command")
    `DEWR_ASSERT(a_ctrl_no_take_in_dump, state_reg == S_DUMP |-> !s_ready, "request taken mid dump")
    `DEWR_ASSERT(a_ctrl_dump_ends, (cmd.dump_step && sts.dump_last) |=> state_reg == S_IDLE, "dump did not end")

endmodule
`default_nettype wire

[rtl/core/dewr_dpath.sv]
`default_nettype none
`include "double_ended_array_with_reverse_top_macros.svh"
module dewr_dpath #(
    parameter int DEPTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire dewr_pkg::dewr_cmd_t       cmd,
    input  wire dewr_pkg::dewr_in_t        in_item,
    input  wire logic                      m_ready,
    output dewr_pkg::dewr_sts_t            sts,
    output logic                           m_valid,
    output dewr_pkg::dewr_out_t            m_item
);
    import dewr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [ELEM_W-1:0] slot_reg  [DEPTH];
    logic signed [ELEM_W-1:0] slot_next [DEPTH];
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            dump_left_reg, dump_left_next;
    logic                     out_valid_reg, out_valid_next;
    dewr_out_t                out_item_reg, out_item_next;

    logic                     full;
    logic                     empty;
    logic [STATUS_W-1:0]      status;
    logic [CW-1:0]            rev_idx;

    assign full  = count_reg == CW'(DEPTH);
    assign empty = count_reg == '0;

    assign sts.cnt_zero  = empty;
    assign sts.out_free  = !out_valid_reg || m_ready;
    assign sts.dump_last = dump_left_reg == CW'(1);

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            dump_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            dump_left_reg <= dump_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        out_item_reg <= out_item_next;
    end

    always_comb begin
        count_next     = count_reg;
        dump_left_next = dump_left_reg;
        status         = STAT_OK;
        rev_idx        = '0;
        for (int i = 0; i < DEPTH; i++) begin
            slot_next[i] = slot_reg[i];
        end

        if (cmd.exec) begin
            unique case (in_item.action)
                ACT_DUMP: begin
                    status = empty ? STAT_EMPTY : STAT_OK;
                end
                ACT_PUSH_BACK: begin
                    if (full) begin
                        status = STAT_FULL;
                    end else begin
                        slot_next[count_reg[IW-1:0]] = in_item.value;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_PUSH_FRONT: begin
                    if (full) begin
                        status = STAT_FULL;
                    end else begin
                        slot_next[0] = in_item.value;
                        for (int i = 1; i < DEPTH; i++) begin
                            slot_next[i] = slot_reg[i-1];
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_POP_BACK: begin
                    if (empty) begin
                        status = STAT_EMPTY;
                    end else begin
                        count_next = count_reg - CW'(1);
                    end
                end
                ACT_POP_FRONT: begin
                    if (empty) begin
                        status = STAT_EMPTY;
                    end else begin
                        for (int i = 0; i < DEPTH - 1; i++) begin
                            slot_next[i] = slot_reg[i+1];
                        end
                        count_next = count_reg - CW'(1);
                    end
                end
                ACT_REVERSE: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CW'(i) < count_reg) begin
                            rev_idx      = count_reg - CW'(1) - CW'(i);
                            slot_next[i] = slot_reg[rev_idx[IW-1:0]];
                        end
                    end
                end
                default: ;
            endcase
        end

        if (cmd.dump_start) begin
            dump_left_next = count_reg;
        end

        // rotate the stored words left by one within the fill
        if (cmd.dump_step) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (CW'(i + 1) < count_reg) begin
                    slot_next[i] = slot_reg[(i + 1) % DEPTH];
                end else if (CW'(i + 1) == count_reg) begin
                    slot_next[i] = slot_reg[0];
                end
            end
            dump_left_next = dump_left_reg - CW'(1);
        end
    end

    always_comb begin
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cmd.exec) begin
            out_valid_next           = 1'b1;
            out_item_next.element    = '0;
            out_item_next.status     = status;
            out_item_next.last       = 1'b1;
            out_item_next.fill_count = FILL_W'(count_next);
        end else if (cmd.dump_step) begin
            out_valid_next           = 1'b1;
            out_item_next.element    = slot_reg[0];
            out_item_next.status     = STAT_OK;
            out_item_next.last       = sts.dump_last;
            out_item_next.fill_count = FILL_W'(count_reg);
        end
    end

    `DEWR_ASSERT(a_dp_count_bound, count_reg <= CW'(DEPTH), "fill count above depth")
    `DEWR_ASSERT(a_dp_dump_live, cmd.dump_step |-> dump_left_reg != '0, "dump step with nothing left")
    `DEWR_ASSERT(a_dp_dump_load, cmd.dump_start |=> dump_left_reg == $past(count_reg), "dump length not loaded")

endmodule
`default_nettype wire

[rtl/core/double_ended_array_with_reverse_top.sv]
// bounded deque of signed 32-bit words with reverse and dump
// input channel s_valid/s_ready/s_item carries one request: action and value
// result channel m_valid/m_ready/m_item carries element, status, last and fill_count
// every request except a non-empty dump gives one result with last set,
// registered and valid the cycle after the request is taken
// a non-empty dump first enters the dump state, then gives one result per
// stored word in order, one per cycle while the result register is free,
// last set on the final word
// s_ready is low while a dump is in progress and while a result waits untaken,
// so a stalled receiver holds the block and no result is dropped
// a push when full is dropped with status full, a pop or dump when empty
// reports status empty; undefined actions give status ok
// aresetn (synchronous, active low) empties the array and clears the result valid
// flag; stored words and the result fields themselves are not cleared
`default_nettype none
module double_ended_array_with_reverse_top #(
    parameter int DEPTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire dewr_pkg::dewr_in_t        s_item,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output dewr_pkg::dewr_out_t            m_item
);
    import dewr_pkg::*;

    dewr_cmd_t cmd;
    dewr_sts_t sts;

    dewr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .action  (s_item.action),
        .sts     (sts),
        .cmd     (cmd)
    );

    dewr_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_item (s_item),
        .m_ready (m_ready),
        .sts     (sts),
        .m_valid (m_valid),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire

[verif/tb_double_ended_array_with_reverse_top.sv]
`timescale 1ns / 100ps

module tb_double_ended_array_with_reverse_top;
    import dewr_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CLK_PERIOD   = 10;
    localparam int DIR_ROWS     = 17;
    localparam int RANDOM_ITEMS = 130;
    localparam int STALL_LIMIT  = 2000;

    // action codes the block treats as no-ops
    localparam logic [ACTION_W-1:0] ACT_SPARE0 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE1 = 3'd7;

    typedef struct packed {
        dewr_in_t  req;
        logic [4:0] reps;
        logic       typed;
        dewr_out_t  want;
    } stim_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    dewr_in_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    dewr_out_t m_item;

    logic signed [ELEM_W-1:0] shadow_words [DEPTH];
    int        shadow_count = 0;
    dewr_out_t step_results [$];
    dewr_out_t due_results [$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    bit        calm        = 1'b0;
    stim_row_t dir_rows [DIR_ROWS];

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    double_ended_array_with_reverse_top #(.DEPTH(DEPTH)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    function automatic stim_row_t stim_row(input logic [ACTION_W-1:0] act,
                                           input logic [ELEM_W-1:0] val, input int reps,
                                           input bit typed, input logic [ELEM_W-1:0] elem,
                                           input logic [STATUS_W-1:0] st,
                                           input logic [FILL_W-1:0] fill);
        stim_row_t row;
        row.req.action      = act;
        row.req.value       = val;
        row.reps            = reps[4:0];
        row.typed           = typed;
        row.want.element    = elem;
        row.want.status     = st;
        row.want.last       = 1'b1;
        row.want.fill_count = fill;
        return row;
    endfunction

    function automatic void predict_deque(input dewr_in_t req);
        dewr_out_t r;
        logic signed [ELEM_W-1:0] tmp;
        r        = '0;
        r.status = STAT_OK;
        r.last   = 1'b1;
        case (req.action)
            ACT_DUMP: begin
                if (shadow_count == 0) r.status = STAT_EMPTY;
            end
            ACT_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_words[shadow_count] = req.value;
                    shadow_count++;
                end
            end
            ACT_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    for (int i = shadow_count; i > 0; i--) shadow_words[i] = shadow_words[i-1];
                    shadow_words[0] = req.value;
                    shadow_count++;
                end
            end
            ACT_POP_BACK: begin
                if (shadow_count == 0) r.status = STAT_EMPTY;
                else shadow_count--;
            end
            ACT_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    for (int i = 0; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                end
            end
            ACT_REVERSE: begin
                for (int i = 0; i < shadow_count / 2; i++) begin
                    tmp = shadow_words[i];
                    shadow_words[i] = shadow_words[shadow_count-1-i];
                    shadow_words[shadow_count-1-i] = tmp;
                end
            end
            default: ;
        endcase
        r.fill_count = shadow_count[FILL_W-1:0];
        if (req.action == ACT_DUMP && shadow_count != 0) begin
            for (int i = 0; i < shadow_count; i++) begin
                r.element = shadow_words[i];
                r.last    = (i == shadow_count - 1);
                step_results.push_back(r);
            end
        end else begin
            step_results.push_back(r);
        end
    endfunction

    task automatic send_request(input dewr_in_t req, input bit typed, input dewr_out_t want);
        s_item  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        step_results.delete();
        predict_deque(req);
        if (typed) begin
            due_results.push_back(want);
        end else begin
            foreach (step_results[i]) due_results.push_back(step_results[i]);
        end
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // hold off new requests until every outstanding result has drained
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input dewr_out_t want,
                                   input dewr_out_t got);
        if (mismatches < 10)
            $display({"%0t: %s: expected element %0d status %0d last %0d fill %0d,",
                      " got element %0d status %0d last %0d fill %0d"},
                     $realtime, what, want.element, want.status, want.last, want.fill_count,
                     got.element, got.status, got.last, got.fill_count);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 10);
    end

    always @(posedge aclk) begin : result_check
        dewr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result", '0, m_item);
            end else begin
                want = due_results.pop_front();
                if (m_item.element !== want.element || m_item.status !== want.status ||
                    m_item.last !== want.last || m_item.fill_count !== want.fill_count)
                    report_mismatch("result mismatch", want, m_item);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_double_ended_array_with_reverse_top failed");
            $finish;
        end
    end

    initial begin
        dewr_in_t req;
        bit       grow;
        int       phase_left;
        int       pick;

        dir_rows = '{
            stim_row(ACT_DUMP,       32'h0,           1, 1, 0,             STAT_EMPTY, 0),
            stim_row(ACT_POP_BACK,   32'h0,           1, 1, 0,             STAT_EMPTY, 0),
            stim_row(ACT_POP_FRONT,  32'h0,           1, 1, 0,             STAT_EMPTY, 0),
            stim_row(ACT_REVERSE,    32'h0,           1, 1, 0,             STAT_OK,    0),
            stim_row(ACT_SPARE0,     32'hFFFF_FFFF,   1, 1, 0,             STAT_OK,    0),
            stim_row(ACT_PUSH_BACK,  32'h7FFF_FFFF,   1, 1, 0,             STAT_OK,    1),
            stim_row(ACT_REVERSE,    32'h0,           1, 1, 0,             STAT_OK,    1),
            stim_row(ACT_DUMP,       32'h0,           1, 1, 32'h7FFF_FFFF, STAT_OK,    1),
            stim_row(ACT_PUSH_FRONT, 32'h8000_0000,   1, 1, 0,             STAT_OK,    2),
            stim_row(ACT_PUSH_BACK,  32'hFFFF_FFFF,   1, 1, 0,             STAT_OK,    3),
            stim_row(ACT_POP_FRONT,  32'h0,           1, 1, 0,             STAT_OK,    2),
            stim_row(ACT_REVERSE,    32'h0,           1, 0, 0,             STAT_OK,    0),
            stim_row(ACT_PUSH_BACK,  32'h1234_5678,  14, 0, 0,             STAT_OK,    0),
            stim_row(ACT_PUSH_BACK,  32'h0,           1, 1, 0,             STAT_FULL,  16),
            stim_row(ACT_PUSH_FRONT, 32'h5555_5555,   1, 1, 0,             STAT_FULL,  16),
            stim_row(ACT_SPARE1,     32'hAAAA_AAAA,   1, 1, 0,             STAT_OK,    16),
            stim_row(ACT_DUMP,       32'h0,           1, 0, 0,             STAT_OK,    0)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                req       = dir_rows[r].req;
                req.value = req.value + k;
                sender_gap();
                send_request(req, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        drain_results();

        grow       = 1'b1;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                grow       = !grow;
                phase_left = $urandom_range(12, 28);
            end
            phase_left--;
            calm = (n >= 100 && n < 140);
            if (n == 80) drain_results();

            pick = $urandom_range(99);
            if (grow) begin
                if (pick < 45)      req.action = ACT_PUSH_BACK;
                else if (pick < 70) req.action = ACT_PUSH_FRONT;
                else if (pick < 78) req.action = ACT_POP_BACK;
                else if (pick < 84) req.action = ACT_POP_FRONT;
                else if (pick < 90) req.action = ACT_REVERSE;
                else if (pick < 97) req.action = ACT_DUMP;
                else                req.action = $urandom_range(1) ? ACT_SPARE1 : ACT_SPARE0;
            end else begin
                if (pick < 10)      req.action = ACT_PUSH_BACK;
                else if (pick < 20) req.action = ACT_PUSH_FRONT;
                else if (pick < 45) req.action = ACT_POP_BACK;
                else if (pick < 70) req.action = ACT_POP_FRONT;
                else if (pick < 80) req.action = ACT_REVERSE;
                else if (pick < 95) req.action = ACT_DUMP;
                else                req.action = $urandom_range(1) ? ACT_SPARE1 : ACT_SPARE0;
            end

            if ($urandom_range(7) == 0) begin
                case ($urandom_range(3))
                    0:       req.value = 32'sh7FFF_FFFF;
                    1:       req.value = 32'sh8000_0000;
                    2:       req.value = '0;
                    default: req.value = '1;
                endcase
            end else begin
                req.value = $urandom;
            end

            sender_gap();
            send_request(req, 1'b0, '0);
        end

        calm = 1'b0;
        drain_results();
        repeat (DEPTH + 8) @(posedge aclk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("tb_double_ended_array_with_reverse_top passed");
        else
            $display("tb_double_ended_array_with_reverse_top failed");
        $finish;
    end

endmodule
